FILE: hw/rtl/imhpq_pkg.sv
// Shared types, codes and constants of the indexed min-heap priority queue.
package imhpq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int NUM_IDS      = 256;
    localparam logic [8:0] CAP_RESET = 9'd256;

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_EMPTY   = 3'd2;
    localparam logic [2:0] STS_ABSENT  = 3'd3;
    localparam logic [2:0] STS_PRESENT = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         elem_id;
        logic signed [31:0] new_priority;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               is_empty;
        logic [7:0]         top_elem;
        logic signed [31:0] top_priority;
        logic               elem_present;
        logic signed [31:0] elem_priority;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] key;
        logic [7:0]         id;
    } entry_t;

    typedef enum logic [4:0] {
        S_IDLE, S_LOOK, S_POS, S_UP_RD, S_UP_CMP, S_PLACE, S_RM1, S_RM2,
        S_DN_RD, S_DN_L, S_DN_R, S_DN_CMP, S_UPD, S_FIN0, S_FIN1, S_FIN2, S_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP, DP_LATCH, DP_INS, DP_RM_TOP, DP_RM_LAST, DP_UPD, DP_UP_MOVE,
        DP_DN_LEFT, DP_DN_RIGHT, DP_DN_MOVE, DP_PLACE, DP_FIN1, DP_FIN2, DP_OUT
    } dp_op_t;

    typedef enum logic [2:0] {
        HR_ROOT, HR_PMV, HR_PARENT, HR_LEFT, HR_RIGHT, HR_LAST
    } hr_sel_t;

    typedef struct packed {
        dp_op_t     op;
        logic       rd_en;
        hr_sel_t    rd_sel;
        logic       pm_rd;
        logic       set_status;
        logic [2:0] status_code;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       pm_present;
        logic       pm_hit;
        logic       full;
        logic       count_zero;
        logic       count_one;
        logic       slot_root;
        logic       left_out;
        logic       right_in;
        logic       cur_lt_rd;
        logic       child_lt_cur;
        logic       pri_lt_rd;
        logic       pri_gt_rd;
        logic       out_free;
    } dp_stat_t;

endpackage

FILE: hw/rtl/indexed_min_heap_priority_queue.sv
// Indexed binary min-heap priority queue: top level joining sequencer and datapath.
// One item at a time: a query goes straight to its result, an insert climbs one level
// per step, a removal or priority raise descends one level per step, so the work grows
// with log2(CAPACITY); the single-port heap memory with registered reads sets the
// per-level cost. The next item is taken while the result waits. Reset empties the
// heap and clears the position map at once.
module indexed_min_heap_priority_queue #(
    parameter int CAPACITY = imhpq_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  imhpq_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output imhpq_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [8:0]           cfg_data
);

    imhpq_pkg::dp_cmd_t  cmd;
    imhpq_pkg::dp_stat_t st;

    assign cfg_ready = 1'b1;

    imhpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    imhpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .st        (st)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while previous item still in work");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat appeared without an item in work");

    a_empty_top_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.is_empty) |->
            (out_data.top_elem == 8'd0 && out_data.top_priority == 32'sd0))
        else $error("empty heap reported a top entry");

    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.elem_present) |-> (out_data.elem_priority == 32'sd0))
        else $error("absent element reported a priority");

endmodule

FILE: hw/rtl/imhpq_ctrl.sv
// Sequencer of the heap operations: issues one datapath command per cycle.
module imhpq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  imhpq_pkg::dp_stat_t st,
    output imhpq_pkg::dp_cmd_t  cmd
);

    imhpq_pkg::state_t state_reg;
    imhpq_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= imhpq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd.op          = imhpq_pkg::DP_NOP;
        cmd.rd_en       = 1'b0;
        cmd.rd_sel      = imhpq_pkg::HR_ROOT;
        cmd.pm_rd       = 1'b0;
        cmd.set_status  = 1'b0;
        cmd.status_code = imhpq_pkg::STS_OK;
        in_stall        = 1'b1;
        case (state_reg)
            imhpq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = imhpq_pkg::DP_LATCH;
                    state_next = imhpq_pkg::S_LOOK;
                end
            end
            imhpq_pkg::S_LOOK:
            begin
                cmd.pm_rd  = 1'b1;
                state_next = imhpq_pkg::S_POS;
            end
            imhpq_pkg::S_POS:
            begin
                state_next = imhpq_pkg::S_FIN0;
                case (st.opcode)
                    imhpq_pkg::OP_INSERT:
                    begin
                        if (st.pm_hit)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = imhpq_pkg::STS_PRESENT;
                        end
                        else if (st.full)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = imhpq_pkg::STS_FULL;
                        end
                        else
                        begin
                            cmd.op     = imhpq_pkg::DP_INS;
                            state_next = imhpq_pkg::S_UP_RD;
                        end
                    end
                    imhpq_pkg::OP_REMOVE:
                    begin
                        if (st.count_zero)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = imhpq_pkg::STS_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = imhpq_pkg::HR_ROOT;
                            state_next = imhpq_pkg::S_RM1;
                        end
                    end
                    imhpq_pkg::OP_UPDATE:
                    begin
                        if (!st.pm_present)
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = imhpq_pkg::STS_ABSENT;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = imhpq_pkg::HR_PMV;
                            state_next = imhpq_pkg::S_UPD;
                        end
                    end
                    default:
                    begin
                        state_next = imhpq_pkg::S_FIN0;
                    end
                endcase
            end
            imhpq_pkg::S_UPD:
            begin
                cmd.op = imhpq_pkg::DP_UPD;
                if (st.pri_lt_rd)
                begin
                    state_next = imhpq_pkg::S_UP_RD;
                end
                else if (st.pri_gt_rd)
                begin
                    state_next = imhpq_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = imhpq_pkg::S_FIN0;
                end
            end
            imhpq_pkg::S_UP_RD:
            begin
                if (st.slot_root)
                begin
                    state_next = imhpq_pkg::S_PLACE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = imhpq_pkg::HR_PARENT;
                    state_next = imhpq_pkg::S_UP_CMP;
                end
            end
            imhpq_pkg::S_UP_CMP:
            begin
                if (st.cur_lt_rd)
                begin
                    cmd.op     = imhpq_pkg::DP_UP_MOVE;
                    state_next = imhpq_pkg::S_UP_RD;
                end
                else
                begin
                    state_next = imhpq_pkg::S_PLACE;
                end
            end
            imhpq_pkg::S_PLACE:
            begin
                cmd.op     = imhpq_pkg::DP_PLACE;
                state_next = imhpq_pkg::S_FIN0;
            end
            imhpq_pkg::S_RM1:
            begin
                cmd.op = imhpq_pkg::DP_RM_TOP;
                if (st.count_one)
                begin
                    state_next = imhpq_pkg::S_FIN0;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = imhpq_pkg::HR_LAST;
                    state_next = imhpq_pkg::S_RM2;
                end
            end
            imhpq_pkg::S_RM2:
            begin
                cmd.op     = imhpq_pkg::DP_RM_LAST;
                state_next = imhpq_pkg::S_DN_RD;
            end
            imhpq_pkg::S_DN_RD:
            begin
                if (st.left_out)
                begin
                    state_next = imhpq_pkg::S_PLACE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = imhpq_pkg::HR_LEFT;
                    state_next = imhpq_pkg::S_DN_L;
                end
            end
            imhpq_pkg::S_DN_L:
            begin
                cmd.op = imhpq_pkg::DP_DN_LEFT;
                if (st.right_in)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = imhpq_pkg::HR_RIGHT;
                    state_next = imhpq_pkg::S_DN_R;
                end
                else
                begin
                    state_next = imhpq_pkg::S_DN_CMP;
                end
            end
            imhpq_pkg::S_DN_R:
            begin
                cmd.op     = imhpq_pkg::DP_DN_RIGHT;
                state_next = imhpq_pkg::S_DN_CMP;
            end
            imhpq_pkg::S_DN_CMP:
            begin
                if (st.child_lt_cur)
                begin
                    cmd.op     = imhpq_pkg::DP_DN_MOVE;
                    state_next = imhpq_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = imhpq_pkg::S_PLACE;
                end
            end
            imhpq_pkg::S_FIN0:
            begin
                cmd.pm_rd  = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = imhpq_pkg::HR_ROOT;
                state_next = imhpq_pkg::S_FIN1;
            end
            imhpq_pkg::S_FIN1:
            begin
                cmd.op     = imhpq_pkg::DP_FIN1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = imhpq_pkg::HR_PMV;
                state_next = imhpq_pkg::S_FIN2;
            end
            imhpq_pkg::S_FIN2:
            begin
                cmd.op     = imhpq_pkg::DP_FIN2;
                state_next = imhpq_pkg::S_OUT;
            end
            imhpq_pkg::S_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.op     = imhpq_pkg::DP_OUT;
                    state_next = imhpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = imhpq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/imhpq_dp.sv
// Heap and position-map memories, working registers and result register.
module imhpq_dp #(
    parameter int CAPACITY = imhpq_pkg::CAPACITY_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  imhpq_pkg::in_item_t  in_data,
    input  logic                 cfg_we,
    input  logic [8:0]           cfg_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output imhpq_pkg::out_item_t out_data,
    input  imhpq_pkg::dp_cmd_t   cmd,
    output imhpq_pkg::dp_stat_t  st
);

    localparam int SW = $clog2(CAPACITY + 1);
    localparam int CW = (SW > 9) ? SW : 9;

    imhpq_pkg::entry_t heap_mem [0:CAPACITY];
    logic [SW-1:0]     pm_mem [0:imhpq_pkg::NUM_IDS-1];

    logic [imhpq_pkg::NUM_IDS-1:0] pm_vld_reg;
    logic [SW-1:0]                 count_reg;
    logic [8:0]                    cap_reg;
    logic                          out_valid_reg;

    imhpq_pkg::entry_t  hrd_reg;
    logic [SW-1:0]      pm_rd_reg;
    logic               pm_rv_reg;
    logic [1:0]         op_reg;
    logic [7:0]         id_reg;
    logic signed [31:0] pri_reg;
    logic [SW-1:0]      slot_reg;
    logic [SW-1:0]      cslot_reg;
    logic [SW-1:0]      pos_reg;
    imhpq_pkg::entry_t  cur_reg;
    imhpq_pkg::entry_t  child_reg;
    imhpq_pkg::entry_t  top_reg;
    logic signed [31:0] elem_key_reg;
    logic [2:0]         status_reg;
    imhpq_pkg::out_item_t out_reg;

    logic [SW-1:0]     pmv;
    logic [SW:0]       left;
    logic [SW:0]       right;
    logic [SW:0]       count_ext;
    logic [SW-1:0]     rd_addr;
    logic              hw_en;
    imhpq_pkg::entry_t hw_data;
    logic              pw_en;
    logic [7:0]        pw_addr;
    logic [CW-1:0]     limit;
    logic [CW-1:0]     cap_ext;
    logic              elem_present;

    assign pmv       = pm_rv_reg ? pm_rd_reg : '0;
    assign left      = {slot_reg, 1'b0};
    assign right     = {slot_reg, 1'b1};
    assign count_ext = {1'b0, count_reg};
    assign cap_ext   = CW'(cap_reg);
    assign limit     = (cap_ext < CW'(CAPACITY)) ? cap_ext : CW'(CAPACITY);
    assign elem_present = (pos_reg != '0) && (pos_reg <= count_reg);

    always_comb
    begin
        case (cmd.rd_sel)
            imhpq_pkg::HR_ROOT:   rd_addr = SW'(1);
            imhpq_pkg::HR_PMV:    rd_addr = pmv;
            imhpq_pkg::HR_PARENT: rd_addr = slot_reg >> 1;
            imhpq_pkg::HR_LEFT:   rd_addr = left[SW-1:0];
            imhpq_pkg::HR_RIGHT:  rd_addr = right[SW-1:0];
            imhpq_pkg::HR_LAST:   rd_addr = count_reg;
            default:              rd_addr = SW'(1);
        endcase
    end

    // Sifting moves a hole: the displaced entry fills it, and the travelling
    // entry is written once where it comes to rest.
    always_comb
    begin
        hw_en   = 1'b0;
        hw_data = cur_reg;
        pw_en   = 1'b0;
        pw_addr = cur_reg.id;
        case (cmd.op)
            imhpq_pkg::DP_UP_MOVE:
            begin
                hw_en   = 1'b1;
                hw_data = hrd_reg;
                pw_en   = 1'b1;
                pw_addr = hrd_reg.id;
            end
            imhpq_pkg::DP_DN_MOVE:
            begin
                hw_en   = 1'b1;
                hw_data = child_reg;
                pw_en   = 1'b1;
                pw_addr = child_reg.id;
            end
            imhpq_pkg::DP_PLACE:
            begin
                hw_en = 1'b1;
                pw_en = 1'b1;
            end
            default:
            begin
                hw_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
        begin
            heap_mem[slot_reg] <= hw_data;
        end
        if (cmd.rd_en)
        begin
            hrd_reg <= heap_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pw_en)
        begin
            pm_mem[pw_addr] <= slot_reg;
        end
        if (cmd.pm_rd)
        begin
            pm_rd_reg <= pm_mem[id_reg];
            pm_rv_reg <= pm_vld_reg[id_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_vld_reg    <= '0;
            count_reg     <= '0;
            cap_reg       <= imhpq_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (pw_en)
            begin
                pm_vld_reg[pw_addr] <= 1'b1;
            end
            if (cmd.op == imhpq_pkg::DP_RM_TOP)
            begin
                pm_vld_reg[hrd_reg.id] <= 1'b0;
                count_reg              <= count_reg - SW'(1);
            end
            if (cmd.op == imhpq_pkg::DP_INS)
            begin
                count_reg <= count_reg + SW'(1);
            end
            if (cmd.op == imhpq_pkg::DP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
        end
        case (cmd.op)
            imhpq_pkg::DP_LATCH:
            begin
                op_reg     <= in_data.opcode;
                id_reg     <= in_data.elem_id;
                pri_reg    <= in_data.new_priority;
                status_reg <= imhpq_pkg::STS_OK;
            end
            imhpq_pkg::DP_INS:
            begin
                slot_reg    <= count_reg + SW'(1);
                cur_reg.key <= pri_reg;
                cur_reg.id  <= id_reg;
            end
            imhpq_pkg::DP_RM_LAST:
            begin
                cur_reg  <= hrd_reg;
                slot_reg <= SW'(1);
            end
            imhpq_pkg::DP_UPD:
            begin
                cur_reg.key <= pri_reg;
                cur_reg.id  <= id_reg;
                slot_reg    <= pmv;
            end
            imhpq_pkg::DP_UP_MOVE:
            begin
                slot_reg <= slot_reg >> 1;
            end
            imhpq_pkg::DP_DN_LEFT:
            begin
                child_reg <= hrd_reg;
                cslot_reg <= left[SW-1:0];
            end
            imhpq_pkg::DP_DN_RIGHT:
            begin
                if (hrd_reg.key < child_reg.key)
                begin
                    child_reg <= hrd_reg;
                    cslot_reg <= right[SW-1:0];
                end
            end
            imhpq_pkg::DP_DN_MOVE:
            begin
                slot_reg <= cslot_reg;
            end
            imhpq_pkg::DP_FIN1:
            begin
                top_reg <= hrd_reg;
                pos_reg <= pmv;
            end
            imhpq_pkg::DP_FIN2:
            begin
                elem_key_reg <= hrd_reg.key;
            end
            imhpq_pkg::DP_OUT:
            begin
                out_reg.status        <= status_reg;
                out_reg.is_empty      <= (count_reg == '0);
                out_reg.top_elem      <= (count_reg == '0) ? 8'd0 : top_reg.id;
                out_reg.top_priority  <= (count_reg == '0) ? 32'sd0 : top_reg.key;
                out_reg.elem_present  <= elem_present;
                out_reg.elem_priority <= elem_present ? elem_key_reg : 32'sd0;
            end
            default:
            begin
                op_reg <= op_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        st.opcode       = op_reg;
        st.pm_hit       = (pmv != '0);
        st.pm_present   = (pmv != '0) && (pmv <= count_reg);
        st.full         = CW'(count_reg) >= limit;
        st.count_zero   = (count_reg == '0);
        st.count_one    = (count_reg == SW'(1));
        st.slot_root    = (slot_reg == SW'(1));
        st.left_out     = left > count_ext;
        st.right_in     = right <= count_ext;
        st.cur_lt_rd    = cur_reg.key < hrd_reg.key;
        st.child_lt_cur = child_reg.key < cur_reg.key;
        st.pri_lt_rd    = pri_reg < hrd_reg.key;
        st.pri_gt_rd    = pri_reg > hrd_reg.key;
        st.out_free     = !out_valid_reg || !out_stall;
    end

endmodule

FILE: bench/indexed_min_heap_priority_queue_test.sv
// Self-checking bench for the indexed min-heap queue over several capacities.
module indexed_min_heap_priority_queue_test;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    imhpq_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    imhpq_pkg::out_item_t out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [8:0]           cfg_data = '0;

    indexed_min_heap_priority_queue i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // Predictor state: slots 1..count hold the heap.
    logic signed [31:0] mdl_key [0:256];
    logic [7:0]         mdl_id  [0:256];
    int unsigned        mdl_pos [0:255];
    int unsigned        mdl_count;
    int unsigned        mdl_cap;

    imhpq_pkg::in_item_t  pending_items[$];
    imhpq_pkg::out_item_t expected_results[$];
    int unsigned n_sent, n_checked, n_errors;
    int unsigned in_gap, out_gap;

    function automatic void swap_slots(input int unsigned a, input int unsigned b);
        logic signed [31:0] k;
        logic [7:0] i;
        k = mdl_key[a]; i = mdl_id[a];
        mdl_key[a] = mdl_key[b]; mdl_id[a] = mdl_id[b];
        mdl_key[b] = k; mdl_id[b] = i;
        mdl_pos[mdl_id[a]] = a;
        mdl_pos[mdl_id[b]] = b;
    endfunction

    function automatic void climb(input int unsigned s);
        while (s > 1 && mdl_key[s] < mdl_key[s / 2])
        begin
            swap_slots(s, s / 2);
            s = s / 2;
        end
    endfunction

    function automatic void descend(input int unsigned s);
        int unsigned c;
        while (s * 2 <= mdl_count)
        begin
            c = s * 2;
            if (c + 1 <= mdl_count && mdl_key[c + 1] < mdl_key[c])
                c++;
            if (mdl_key[c] < mdl_key[s])
            begin
                swap_slots(s, c);
                s = c;
            end
            else
                break;
        end
    endfunction

    function automatic imhpq_pkg::out_item_t heap_step(input imhpq_pkg::in_item_t it);
        imhpq_pkg::out_item_t r;
        int unsigned p, last, lim;
        logic signed [31:0] old;
        r = '0;
        r.status = imhpq_pkg::STS_OK;
        lim = (mdl_cap < 256) ? mdl_cap : 256;
        p = mdl_pos[it.elem_id];
        case (it.opcode)
            imhpq_pkg::OP_INSERT:
                if (p != 0)
                    r.status = imhpq_pkg::STS_PRESENT;
                else if (mdl_count >= lim)
                    r.status = imhpq_pkg::STS_FULL;
                else
                begin
                    mdl_count++;
                    mdl_key[mdl_count] = it.new_priority;
                    mdl_id[mdl_count] = it.elem_id;
                    mdl_pos[it.elem_id] = mdl_count;
                    climb(mdl_count);
                end
            imhpq_pkg::OP_REMOVE:
                if (mdl_count == 0)
                    r.status = imhpq_pkg::STS_EMPTY;
                else
                begin
                    last = mdl_count;
                    mdl_pos[mdl_id[1]] = 0;
                    mdl_count--;
                    if (last > 1)
                    begin
                        mdl_key[1] = mdl_key[last];
                        mdl_id[1] = mdl_id[last];
                        mdl_pos[mdl_id[1]] = 1;
                        descend(1);
                    end
                end
            imhpq_pkg::OP_UPDATE:
                if (p == 0 || p > mdl_count)
                    r.status = imhpq_pkg::STS_ABSENT;
                else
                begin
                    old = mdl_key[p];
                    mdl_key[p] = it.new_priority;
                    if (it.new_priority < old)
                        climb(p);
                    else if (it.new_priority > old)
                        descend(p);
                end
            default: ;
        endcase
        r.is_empty = (mdl_count == 0);
        if (mdl_count != 0)
        begin
            r.top_elem = mdl_id[1];
            r.top_priority = mdl_key[1];
        end
        p = mdl_pos[it.elem_id];
        if (p != 0 && p <= mdl_count)
        begin
            r.elem_present = 1'b1;
            r.elem_priority = mdl_key[p];
        end
        return r;
    endfunction

    // Driver: one beat per pending item, with a random gap before each.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(heap_step(in_data));
                n_sent++;
                void'(pending_items.pop_front());
                in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                if (in_gap == 0 && pending_items.size() > 0)
                    in_data <= pending_items[0];
                in_valid <= (in_gap == 0 && pending_items.size() > 0);
            end
            else if (!in_valid)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_items.size() > 0)
                begin
                    in_data <= pending_items[0];
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: compares every result beat with the oldest expectation and stalls the output at random.
    always @(posedge clk)
    begin
        imhpq_pkg::out_item_t e;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result beat %p", out_data);
                end
                else
                begin
                    e = expected_results.pop_front();
                    n_checked++;
                    if (out_data !== e)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d mismatch: expected %p actual %p",
                                     n_checked, e, out_data);
                    end
                end
                out_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
                out_stall <= (out_gap != 0);
            end
            else if (out_stall)
            begin
                if (out_gap > 0)
                    out_gap--;
                if (out_gap <= 1)
                    out_stall <= 1'b0;
            end
        end
    end

    function automatic imhpq_pkg::in_item_t mk(input logic [1:0] op, input logic [7:0] id,
                                               input logic signed [31:0] pr);
        imhpq_pkg::in_item_t t;
        t.opcode = op;
        t.elem_id = id;
        t.new_priority = pr;
        return t;
    endfunction

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_capacity(input int unsigned v);
        @(posedge clk);
        cfg_data <= v[8:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        mdl_cap = v;
    endtask

    // Random phase: an id pool narrower than 256 makes ids recur and the heap fill.
    task automatic random_phase(input int unsigned n, input int unsigned ids);
        imhpq_pkg::in_item_t t;
        int unsigned w;
        for (int k = 0; k < n; k++)
        begin
            w = $urandom_range(0, 99);
            t.opcode = (w < 40) ? imhpq_pkg::OP_INSERT : (w < 65) ? imhpq_pkg::OP_REMOVE :
                       (w < 90) ? imhpq_pkg::OP_UPDATE : imhpq_pkg::OP_QUERY;
            t.elem_id = (ids >= 256) ? 8'($urandom) : 8'($urandom_range(0, ids - 1));
            case ($urandom_range(0, 5))
                0: t.new_priority = 32'sh7FFFFFFF;
                1: t.new_priority = 32'sh80000000;
                2: t.new_priority = $signed(32'($urandom_range(0, 15)) - 32'd8);
                default: t.new_priority = $urandom;
            endcase
            pending_items.push_back(t);
        end
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
            mdl_pos[i] = 0;
        mdl_count = 0;
        mdl_cap = 256;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty removal, absent update, duplicate insert, extremes.
        pending_items.push_back(mk(imhpq_pkg::OP_QUERY, 8'd0, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_REMOVE, 8'd5, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_UPDATE, 8'd7, 32'sd3));
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd255, 32'sh7FFFFFFF));
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd0, 32'sh80000000));
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd0, 32'sd1));
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd17, 32'sd100));
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd18, 32'sd50));
        pending_items.push_back(mk(imhpq_pkg::OP_UPDATE, 8'd18, 32'sd50));
        pending_items.push_back(mk(imhpq_pkg::OP_UPDATE, 8'd0, 32'sd200));
        pending_items.push_back(mk(imhpq_pkg::OP_UPDATE, 8'd255, -32'sd9));
        pending_items.push_back(mk(imhpq_pkg::OP_QUERY, 8'd17, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_REMOVE, 8'd0, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_REMOVE, 8'd0, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_REMOVE, 8'd0, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_REMOVE, 8'd0, 0));
        pending_items.push_back(mk(imhpq_pkg::OP_REMOVE, 8'd0, 0));
        drain();

        write_capacity(1);
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd3, 32'sd4));
        pending_items.push_back(mk(imhpq_pkg::OP_INSERT, 8'd4, 32'sd2));
        random_phase(150, 8);
        drain();
        write_capacity(0);
        random_phase(60, 8);
        drain();
        write_capacity(5);
        random_phase(300, 12);
        drain();
        write_capacity(511);
        random_phase(600, 256);
        drain();
        write_capacity(256);
        random_phase(500, 64);
        drain();
        write_capacity(3);   // below the current count: only inserts refused
        random_phase(150, 64);
        drain();
        write_capacity(200);
        random_phase(240, 256);
        drain();

        $display("covered %0d items, %0d results checked, capacities 0 to 511",
                 n_sent, n_checked);
        if (n_errors == 0)
            $display("indexed_min_heap_priority_queue_test: clean");
        else
            $display("indexed_min_heap_priority_queue_test: errors");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("indexed_min_heap_priority_queue_test: errors");
        $finish;
    end
endmodule

FILE: filelist.f
hw/rtl/imhpq_pkg.sv
hw/rtl/imhpq_ctrl.sv
hw/rtl/imhpq_dp.sv
hw/rtl/indexed_min_heap_priority_queue.sv
bench/indexed_min_heap_priority_queue_test.sv
